FILE: hdl/linear_probe_hash_table_defines.svh
// Assertion helpers for the hash table RTL.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/lpht_pkg.sv
package lpht_pkg;

    localparam int unsigned TABLE_DEPTH_DEFAULT = 1024;

    localparam int unsigned CFG_W = 4;
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 4'd10;
    localparam int unsigned LG_MIN = 3;

    localparam int unsigned DATA_W = 32;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    localparam int unsigned STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RESERVED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_PROBE
    } t_state;

endpackage

FILE: hdl/linear_probe_hash_table.sv
// Open-addressing key/value table with linear probing.
// Input channel: present i_operation/i_key/i_value with start; the beat is
// taken at a rising edge where start is high and busy is low.
// Result channel: o_result_valid strobes for one cycle with o_result_value
// and o_status; the receiver cannot stall, so every strobe is consumed.
// Config: i_cfg_we writes i_cfg_wdata into r_size_log2 (write when idle).
// Timing: each memory probe is one read of the key and value RAMs; an op
// needs k probes, k from 1 to 2^L. The next beat can be taken in the cycle
// the result of the last is shown, so a new beat is not taken before the
// last one is answered. A reserved key is answered, without probing, in the
// cycle after it is taken. The probe walk through the single-read-port RAM sets the rate.
// Reset: a clearing pass writes all-ones into every slot, one slot per cycle,
// 2^floor(log2(TABLE_DEPTH)) slots (1024 by default); busy stays high until
// it finishes. Config writes are still taken during the pass.
module linear_probe_hash_table #(
    parameter int unsigned TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic [lpht_pkg::DATA_W-1:0]   i_key,
    input  logic [lpht_pkg::DATA_W-1:0]   i_value,
    output logic                          o_result_valid,
    output logic [lpht_pkg::DATA_W-1:0]   o_result_value,
    output logic [lpht_pkg::STATUS_W-1:0] o_status,
    input  logic                          i_cfg_we,
    input  logic [lpht_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import lpht_pkg::*;

    `include "linear_probe_hash_table_defines.svh"

    // Largest L with 2^L <= depth; slot index width follows from it.
    localparam int unsigned MAX_LG = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int unsigned AW     = MAX_LG;
    localparam int unsigned SLOTS  = 1 << AW;
    localparam int unsigned LG_W   = 5;

    // Key and value RAMs, one write and one registered read port each.
    logic [DATA_W-1:0] key_mem [SLOTS];
    logic [DATA_W-1:0] val_mem [SLOTS];

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_size_log2;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_addr, n_addr;   // slot whose data is on the read regs
    logic [AW-1:0]       r_cnt, n_cnt;     // probes done minus one
    logic                r_op;
    logic [DATA_W-1:0]   r_key;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_key_rd;
    logic [DATA_W-1:0]   r_val_rd;
    logic                r_result_valid, n_result_valid;
    logic [DATA_W-1:0]   r_result_value, n_result_value;
    logic [STATUS_W-1:0] r_status, n_status;

    logic [LG_W-1:0]     lg_eff;
    logic [AW-1:0]       mask;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_key;
    logic [DATA_W-1:0]   wr_val;
    logic                accept;
    logic                key_hit;
    logic                key_empty;

    // Effective table size: config saturated to [3, MAX_LG].
    always_comb begin
        lg_eff = {1'b0, r_size_log2};
        if (lg_eff < LG_W'(LG_MIN)) begin
            lg_eff = LG_W'(LG_MIN);
        end else if (lg_eff > LG_W'(MAX_LG)) begin
            lg_eff = LG_W'(MAX_LG);
        end
        for (int i = 0; i < AW; i++) begin
            mask[i] = (LG_W'(i) < lg_eff);
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign key_hit   = (r_key_rd == r_key);
    assign key_empty = (r_key_rd == ALL_ONES);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && (i_key != ALL_ONES)) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (key_hit || key_empty || (r_cnt == mask)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory control, probe walk and result
    always_comb begin
        rd_addr        = r_addr;
        n_addr         = r_addr;
        n_cnt          = r_cnt;
        wr_en          = 1'b0;
        wr_addr        = r_addr;
        wr_key         = r_key;
        wr_val         = r_val;
        n_result_valid = 1'b0;
        n_result_value = ALL_ONES;
        n_status       = STATUS_OK;
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_key  = ALL_ONES;
                wr_val  = ALL_ONES;
            end
            S_IDLE: begin
                // home slot is the key itself, masked
                rd_addr = i_key[AW-1:0] & mask;
                n_addr  = rd_addr;
                n_cnt   = '0;
                if (accept && (i_key == ALL_ONES)) begin
                    n_result_valid = 1'b1;
                    n_status       = STATUS_RESERVED;
                end
            end
            S_PROBE: begin
                if (key_hit) begin
                    n_result_valid = 1'b1;
                    n_result_value = r_val_rd;
                    wr_en          = (r_op == OP_SET);
                end else if (key_empty) begin
                    // empty slot never holds a value
                    n_result_valid = 1'b1;
                    wr_en          = (r_op == OP_SET);
                end else if (r_cnt == mask) begin
                    n_result_valid = 1'b1;
                    n_status       = STATUS_FULL;
                end else begin
                    rd_addr = (r_addr + 1'b1) & mask;
                    n_addr  = rd_addr;
                    n_cnt   = r_cnt + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
        r_key_rd <= key_mem[rd_addr];
        r_val_rd <= val_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_size_log2    <= CFG_SIZE_RESET;
            r_clr_addr     <= '0;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_result_valid <= n_result_valid;
            if (i_cfg_we) begin
                r_size_log2 <= i_cfg_wdata;
            end
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr         <= n_addr;
        r_cnt          <= n_cnt;
        r_result_value <= n_result_value;
        r_status       <= n_status;
        if (accept) begin
            r_op  <= i_operation;
            r_key <= i_key;
            r_val <= i_value;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result_value = r_result_value;
    assign o_status       = r_status;

    `LPHT_ASSERT_NEXT(a_reserved_reply, i_clk, i_rst_n, accept && (i_key == ALL_ONES), o_result_valid && (o_status == STATUS_RESERVED), "reserved key not answered next cycle")
    `LPHT_ASSERT_NEXT(a_probe_start, i_clk, i_rst_n, accept && (i_key != ALL_ONES), r_state == S_PROBE, "accepted key did not start probing")
    `LPHT_ASSERT_NOW(a_write_window, i_clk, i_rst_n, wr_en, (r_state == S_CLEAR) || (r_state == S_PROBE), "RAM write outside clear or probe")
    `LPHT_ASSERT_NEXT(a_probe_done, i_clk, i_rst_n, (r_state == S_PROBE) && (n_state == S_IDLE), o_result_valid, "probe ended without a result")
    `LPHT_ASSERT_NOW(a_no_idle_result, i_clk, i_rst_n, o_result_valid && (o_status == STATUS_FULL), $past(r_state) == S_PROBE, "full status without a probe")

endmodule

FILE: tb/sv/linear_probe_hash_table_tb.sv
`timescale 1ns / 100ps

module linear_probe_hash_table_tb;
    import lpht_pkg::*;

    // Sized to match the instance below.
    localparam int unsigned SLOT_DEPTH = TABLE_DEPTH_DEFAULT;
    // Largest usable log2 size: floor(log2(SLOT_DEPTH)).
    localparam int unsigned LG_MAX = $clog2(SLOT_DEPTH + 1) - 1;
    // Idle cycles after the last result before a size write or the end.
    localparam int unsigned HOLD_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES = 20;
    // Worst case is every access a full sweep; allow ~6x that.
    localparam int unsigned TIMEOUT_NS = 100_000_000;
    localparam int unsigned MAX_SHOWN = 10;
    localparam int unsigned KEY_POOL_MAX = 512;

    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
    } t_table_req;

    typedef struct packed {
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } t_table_rsp;

    // DUT inputs, all known from time zero.
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                i_operation = OP_GET;
    logic [DATA_W-1:0]   i_key       = '0;
    logic [DATA_W-1:0]   i_value     = '0;
    logic                i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata = '0;

    logic                busy;
    logic                o_result_valid;
    logic [DATA_W-1:0]   o_result_value;
    logic [STATUS_W-1:0] o_status;

    // Stimulus and scoreboard state.
    t_table_req      pending_ops[$];
    t_table_rsp      results_due[$];
    logic [DATA_W-1:0] known_keys[$];
    logic            beat_taken   = 1'b0;  // set by monitor, cleared by driver
    logic            steady_drive = 1'b0;  // no input gaps while high

    // Shadow copy of the block's store and size register.
    logic [DATA_W-1:0] key_mem[SLOT_DEPTH];
    logic [DATA_W-1:0] val_mem[SLOT_DEPTH];
    logic [CFG_W-1:0]  size_cfg = CFG_SIZE_RESET;

    int unsigned n_beats      = 0;
    int unsigned n_checked    = 0;
    int unsigned n_full       = 0;
    int unsigned n_reserved   = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned n_errors     = 0;

    linear_probe_hash_table #(
        .TABLE_DEPTH(SLOT_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_operation   (i_operation),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_result_valid(o_result_valid),
        .o_result_value(o_result_value),
        .o_status      (o_status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Walk the probe sequence on the shadow store and apply the access.
    // Size register saturates to [LG_MIN, LG_MAX]; slots from 2^L up are left alone.
    function automatic t_table_rsp probe_and_apply(t_table_req req);
        t_table_rsp  rsp;
        int unsigned lg;
        int unsigned slots;
        int unsigned slot;
        int unsigned p;
        rsp.value  = ALL_ONES;
        rsp.status = STATUS_FULL;
        if (req.key == ALL_ONES) begin
            rsp.status = STATUS_RESERVED;
            return rsp;
        end
        lg = size_cfg;
        if (lg < LG_MIN) lg = LG_MIN;
        if (lg > LG_MAX) lg = LG_MAX;
        slots = 1 << lg;
        for (p = 0; p < slots; p++) begin
            slot = (req.key + p) & (slots - 1);
            if (key_mem[slot] == req.key) begin
                // Existing key: hand back old value, overwrite on set.
                rsp.value  = val_mem[slot];
                rsp.status = STATUS_OK;
                if (req.op == OP_SET) val_mem[slot] = req.value;
                return rsp;
            end
            if (key_mem[slot] == ALL_ONES) begin
                // Empty slot ends the walk; a set claims it.
                rsp.status = STATUS_OK;
                if (req.op == OP_SET) begin
                    key_mem[slot] = req.key;
                    rsp.value     = val_mem[slot];
                    val_mem[slot] = req.value;
                end
                return rsp;
            end
        end
        return rsp;  // full sweep, nothing written
    endfunction

    // Random access: mix of pool hits, keys clustered on low home slots,
    // reserved key and fully random keys.
    function automatic t_table_req random_access();
        t_table_req  req;
        int unsigned pick;
        req.op = ($urandom_range(1) != 0) ? OP_SET : OP_GET;
        pick = $urandom_range(99);
        if (pick < 4)
            req.key = ALL_ONES;
        else if (pick < 48 && known_keys.size() != 0)
            req.key = known_keys[$urandom_range(known_keys.size() - 1)];
        else if (pick < 68)
            req.key = ($urandom() & ~32'h3FF) | $urandom_range(15);
        else
            req.key = $urandom();
        pick = $urandom_range(99);
        if (pick < 10)      req.value = ALL_ONES;  // delete marker
        else if (pick < 15) req.value = '0;
        else                req.value = $urandom();
        if (req.op == OP_SET && req.key != ALL_ONES && known_keys.size() < KEY_POOL_MAX)
            known_keys.push_back(req.key);
        return req;
    endfunction

    task automatic queue_access(input logic op, input logic [DATA_W-1:0] key,
                                input logic [DATA_W-1:0] value);
        pending_ops.push_back('{op: op, key: key, value: value});
    endtask

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
                                   input logic [DATA_W-1:0] got);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
    endtask

    // Wait until every beat is taken and answered, then let the block settle.
    // Checked just after the falling edge so the driver's update is visible.
    task automatic drain();
        do begin
            @(negedge i_clk);
            #1;
        end while (pending_ops.size() != 0 || start || results_due.size() != 0);
        repeat (HOLD_CYCLES) @(negedge i_clk);
    endtask

    // Size write while idle; ends on a rising edge so new items are queued
    // away from the driver's falling-edge update.
    task automatic write_size(input logic [CFG_W-1:0] lg);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= lg;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        n_cfg_writes++;
        @(posedge i_clk);
    endtask

    // Driver: present the next beat at the falling edge once the previous one
    // was taken; random gaps unless steady_drive is set.
    always @(negedge i_clk) begin : drive
        t_table_req req;
        if (i_rst_n && (!start || beat_taken)) begin
            if (pending_ops.size() != 0 && (steady_drive || $urandom_range(99) >= 13)) begin
                req = pending_ops.pop_front();
                start       <= 1'b1;
                i_operation <= req.op;
                i_key       <= req.key;
                i_value     <= req.value;
            end else begin
                start <= 1'b0;
            end
        end
        beat_taken = 1'b0;
    end

    // Monitor: size writes and accepted beats update the shadow store in
    // edge order; each result strobe is checked against the oldest prediction.
    always @(posedge i_clk) begin : observe
        t_table_rsp want;
        if (i_rst_n) begin
            if (i_cfg_we) size_cfg = i_cfg_wdata;
            if (o_result_valid) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result", '0, o_result_value);
                end else begin
                    want = results_due.pop_front();
                    n_checked++;
                    if (want.status == STATUS_FULL)     n_full++;
                    if (want.status == STATUS_RESERVED) n_reserved++;
                    if (o_result_value !== want.value)
                        report_mismatch("result_value", want.value, o_result_value);
                    if (o_status !== want.status)
                        report_mismatch("status", DATA_W'(want.status), DATA_W'(o_status));
                end
            end
            if (start && !busy) begin
                results_due.push_back(probe_and_apply('{op: i_operation, key: i_key,
                                                        value: i_value}));
                n_beats++;
                beat_taken = 1'b1;
            end
        end
    end

    initial begin : run_limit
        #TIMEOUT_NS;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_W-1:0] sizes[10];
        int unsigned i;
        int unsigned k;
        sizes = '{4'd15, 4'd3, 4'd7, 4'd10, 4'd5,
                  4'd2, 4'd12, 4'd8, 4'd4, 4'd10};
        for (i = 0; i < SLOT_DEPTH; i++) begin
            key_mem[i] = ALL_ONES;
            val_mem[i] = ALL_ONES;
        end
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size (1024 slots). Beats queue up behind the clearing pass.
        queue_access(OP_GET, 32'h0000_0000, 32'h1234_5678);  // empty table miss
        queue_access(OP_GET, ALL_ONES, 32'h0);                // reserved key
        queue_access(OP_SET, ALL_ONES, 32'h5555_5555);        // reserved, no write
        queue_access(OP_SET, 32'h0000_0000, 32'h0000_0000);
        queue_access(OP_SET, 32'h0000_0000, ALL_ONES);        // delete, returns 0
        queue_access(OP_GET, 32'h0000_0000, 32'h0);           // deleted -> all-ones
        queue_access(OP_SET, 32'h0000_0400, 32'hFFFF_FFFE);   // collides with key 0
        queue_access(OP_GET, 32'h0000_0400, 32'h0);
        queue_access(OP_SET, 32'h0000_03FF, 32'hA5A5_A5A5);   // top slot
        queue_access(OP_SET, 32'hFFFF_FFFE, 32'h5A5A_5A5A);   // largest legal key
        queue_access(OP_SET, 32'h0000_07FF, 32'h8000_0000);   // wraps to slot 2
        queue_access(OP_GET, 32'h0000_07FF, 32'h0);
        drain();

        // Size below range saturates to 8 slots; old entries stay put.
        write_size(4'd0);
        for (k = 8; k <= 13; k++)
            queue_access(OP_SET, k, 32'hC0DE_0000 | k);       // last one finds no slot
        queue_access(OP_GET, 32'h1234_5678, 32'h0);           // miss on a full table
        queue_access(OP_GET, 32'h0000_0400, 32'h0);
        queue_access(OP_SET, 32'h0000_07FF, 32'h0000_0001);   // hit after wrap
        drain();

        // Random phases over a spread of sizes, extremes included.
        for (i = 0; i < 10; i++) begin
            write_size(sizes[i]);
            steady_drive = (i == 3);  // one long gap-free stretch
            for (k = 0; k < 153; k++)
                pending_ops.push_back(random_access());
            drain();
        end
        steady_drive = 1'b0;
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (results_due.size() != 0) begin
            n_errors++;
            $display("%0d predicted results never arrived", results_due.size());
        end
        $display("Covered %0d accesses over %0d size writes: %0d full sweeps, %0d reserved keys.",
                 n_beats, n_cfg_writes, n_full, n_reserved);
        $display("Checked %0d results, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
